// ===== src/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants and types for the text console writer: screen geometry,
// operation codes, character codes and the sequencer state type.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int COLS   = 80;
    localparam int ROWS   = 25;
    localparam int NCELLS = COLS * ROWS;

    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int CELL_W = $clog2(NCELLS + 1);

    localparam int IN_W   = 40;
    localparam int OUT_W  = 32;

    localparam logic [1:0] FUNC_PUT   = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    localparam logic CFG_DEFAULT_ATTR = 1'b0;
    localparam logic CFG_ERROR_ATTR   = 1'b1;

    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_ERROR     = 8'h45;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_BLANK     = 8'h00;

    localparam logic [7:0] RESET_DEFAULT_ATTR = 8'd15;
    localparam logic [7:0] RESET_ERROR_ATTR   = 8'd4;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_RD_WAIT,
        ST_FILL,
        ST_SCROLL,
        ST_DONE
    } t_state;

endpackage

// ===== src/text_console_writer.sv =====
// ----------------------------------------------------------------------------
// text_console_writer
// Character-cell text console: a screen memory of character/attribute
// pairs, a cursor, put/read/clear operations, and scrolling.
// ----------------------------------------------------------------------------
// Sequence: a put writes its cell as it is accepted, a read waits for the
// registered memory read, clear fills every cell, and a put that runs off the
// last row adds a scroll pass; each result goes out through a result register.
// One item at a time: a new item is taken only after the last result is
// registered. Reset: synchronous, active low; afterwards a clearing pass
// fills the memory with spaces before the first item is taken.
// ----------------------------------------------------------------------------
module text_console_writer
    import tcw_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [7:0]       i_cfg_data,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // func[1:0], ch[9:2], attr[17:10], at_cursor[18], col[26:19], row[34:27]
    input  logic [IN_W-1:0]  s_axis_tdata,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // cursor_col[6:0], cursor_row[11:7], cell_char[19:12], cell_attr[27:20],
    // off_screen[28]
    output logic [OUT_W-1:0] m_axis_tdata
);

    t_state              r_state, n_state;
    logic [CELL_W-1:0]   r_cnt;
    logic [COL_W-1:0]    r_cur_col, n_cur_col;
    logic [ROW_W-1:0]    r_cur_row, n_cur_row;
    logic                r_off;
    logic [7:0]          r_cell_char, r_cell_attr;
    logic [7:0]          r_default_attr, r_error_attr;
    logic                r_out_valid;
    logic [OUT_W-1:0]    r_out_data;
    logic [15:0]         r_rd_data;
    logic [15:0]         mem [NCELLS];

    logic [1:0]          w_func;
    logic [7:0]          w_ch, w_attr, w_col, w_row, w_attr_eff;
    logic                w_at_cur, w_outside, w_accept, w_scroll, w_out_free;
    logic [COL_W-1:0]    w_pcol;
    logic [ROW_W-1:0]    w_prow;
    logic [CELL_W-1:0]   w_paddr;
    logic                w_we;
    logic [CELL_W-1:0]   w_waddr, w_raddr, w_cnt_m1;
    logic [15:0]         w_wdata;

    assign w_func     = s_axis_tdata[1:0];
    assign w_ch       = s_axis_tdata[9:2];
    assign w_attr     = s_axis_tdata[17:10];
    assign w_at_cur   = s_axis_tdata[18];
    assign w_col      = s_axis_tdata[26:19];
    assign w_row      = s_axis_tdata[34:27];

    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_outside  = !w_at_cur && (w_col >= 8'(COLS) || w_row >= 8'(ROWS));
    assign w_pcol     = w_at_cur ? r_cur_col : w_col[COL_W-1:0];
    assign w_prow     = w_at_cur ? r_cur_row : w_row[ROW_W-1:0];
    assign w_paddr    = CELL_W'(w_prow) * CELL_W'(COLS) + CELL_W'(w_pcol);
    assign w_attr_eff = (w_attr == 8'd0) ? r_default_attr : w_attr;
    assign w_cnt_m1   = r_cnt - CELL_W'(1);

    // cursor move of a put inside the screen
    always_comb begin
        n_cur_col = w_pcol;
        n_cur_row = w_prow;
        w_scroll  = 1'b0;
        case (w_ch)
            CH_NEWLINE: begin
                n_cur_col = '0;
                if (w_prow == ROW_W'(ROWS - 1)) begin
                    w_scroll = 1'b1;
                end else begin
                    n_cur_row = w_prow + ROW_W'(1);
                end
            end
            CH_BACKSPACE: begin
                if (w_pcol != '0) begin
                    n_cur_col = w_pcol - COL_W'(1);
                end else if (w_prow != '0) begin
                    n_cur_col = COL_W'(COLS - 1);
                    n_cur_row = w_prow - ROW_W'(1);
                end
            end
            default: begin
                if (w_pcol == COL_W'(COLS - 1)) begin
                    n_cur_col = '0;
                    if (w_prow == ROW_W'(ROWS - 1)) begin
                        w_scroll = 1'b1;
                    end else begin
                        n_cur_row = w_prow + ROW_W'(1);
                    end
                end else begin
                    n_cur_col = w_pcol + COL_W'(1);
                end
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_INIT: begin
                if (r_cnt == CELL_W'(NCELLS - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (w_accept) begin
                    unique case (w_func)
                        FUNC_PUT:   n_state = (!w_outside && w_scroll) ? ST_SCROLL : ST_DONE;
                        FUNC_READ:  n_state = w_outside ? ST_DONE : ST_RD_WAIT;
                        FUNC_CLEAR: n_state = ST_FILL;
                        default:    n_state = ST_DONE;
                    endcase
                end
            end
            ST_RD_WAIT: n_state = ST_DONE;
            ST_FILL: begin
                if (r_cnt == CELL_W'(NCELLS - 1)) n_state = ST_DONE;
            end
            ST_SCROLL: begin
                if (r_cnt == CELL_W'(NCELLS)) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (w_out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // memory port and handshake controls
    always_comb begin
        s_axis_tready = 1'b0;
        w_we          = 1'b0;
        w_waddr       = r_cnt;
        w_wdata       = {RESET_DEFAULT_ATTR, CH_SPACE};
        w_raddr       = w_paddr;
        unique case (r_state)
            ST_INIT: begin
                w_we = 1'b1;
            end
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (w_accept && w_func == FUNC_PUT) begin
                    if (w_outside) begin
                        w_we    = 1'b1;
                        w_waddr = CELL_W'(NCELLS - 1);
                        w_wdata = {r_error_attr, CH_ERROR};
                    end else if (w_ch == CH_BACKSPACE) begin
                        w_we    = 1'b1;
                        w_waddr = (w_paddr != '0) ? w_paddr - CELL_W'(1) : w_paddr;
                        w_wdata = {r_default_attr, CH_BLANK};
                    end else if (w_ch != CH_NEWLINE) begin
                        w_we    = 1'b1;
                        w_waddr = w_paddr;
                        w_wdata = {w_attr_eff, w_ch};
                    end
                end
            end
            ST_FILL: begin
                w_we    = 1'b1;
                w_wdata = {r_default_attr, CH_SPACE};
            end
            ST_SCROLL: begin
                w_raddr = (r_cnt < CELL_W'(NCELLS - COLS)) ? r_cnt + CELL_W'(COLS) : '0;
                w_we    = (r_cnt != '0);
                w_waddr = w_cnt_m1;
                w_wdata = (w_cnt_m1 < CELL_W'(NCELLS - COLS)) ? r_rd_data : 16'h0000;
            end
            default: begin
            end
        endcase
    end

    // screen memory
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        r_rd_data <= mem[w_raddr];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_INIT;
            r_cnt          <= '0;
            r_cur_col      <= '0;
            r_cur_row      <= '0;
            r_default_attr <= RESET_DEFAULT_ATTR;
            r_error_attr   <= RESET_ERROR_ATTR;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_IDLE) begin
                r_cnt <= '0;
            end else if (r_state == ST_INIT || r_state == ST_FILL || r_state == ST_SCROLL) begin
                r_cnt <= r_cnt + CELL_W'(1);
            end
            if (w_accept && w_func == FUNC_PUT && !w_outside) begin
                r_cur_col <= n_cur_col;
                r_cur_row <= n_cur_row;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_DEFAULT_ATTR: r_default_attr <= i_cfg_data;
                    CFG_ERROR_ATTR:   r_error_attr   <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (r_state == ST_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_off       <= w_outside && (w_func == FUNC_PUT || w_func == FUNC_READ);
            r_cell_char <= 8'd0;
            r_cell_attr <= 8'd0;
        end else if (r_state == ST_RD_WAIT) begin
            r_cell_char <= r_rd_data[7:0];
            r_cell_attr <= r_rd_data[15:8];
        end
        if (r_state == ST_DONE && w_out_free) begin
            r_out_data <= {3'b000, r_off, r_cell_attr, r_cell_char, r_cur_row, r_cur_col};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule
